/* rtl/sitd_pkg.sv */
package sitd_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned StepW   = 32;
  localparam int unsigned GainW   = 15;
  localparam int unsigned DelayW  = 6;
  localparam int unsigned PanW    = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned ShiftQ  = 15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PHASE_STEP    = 3'd0,
    REG_GAIN_LEFT     = 3'd1,
    REG_GAIN_RIGHT    = 3'd2,
    REG_ITD_DELAY     = 3'd3,
    REG_PAN_DIRECTION = 3'd4
  } cfg_reg_e;

  localparam logic [PanW-1:0] PanLeft = 2'b01;

  localparam logic [63:0] TwoPiFMant = 64'd13176795;
  localparam logic [63:0] HalfPiQ60  = 64'h1921FB54442D1847;
  localparam logic [63:0] OneQ60     = 64'h1000000000000000;
  localparam logic [63:0] PosMax     = 64'h000000007FFFFFFF;
  localparam logic [63:0] NegMax     = 64'h0000000080000000;

  function automatic logic [63:0] round_sig(input logic [63:0] v, input int bits);
    int          m;
    int          s;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    m = -1;
    for (int b = 0; b < 64; b++) begin
      if (v[b]) m = b;
    end
    if (m < bits) return v;
    s    = m - bits + 1;
    q    = v >> s;
    rem  = v & ((64'd1 << s) - 64'd1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q << s;
  endfunction

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [SampleW-1:0] sine_entry(input int unsigned idx,
                                                    input int unsigned lg);
    logic [63:0] p;
    logic [63:0] x;
    logic [63:0] k;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] sp;
    logic [63:0] sn;
    logic [63:0] cp;
    logic [63:0] cn;
    logic [63:0] sv;
    logic [63:0] cv;
    logic [63:0] v;
    logic [63:0] mag;
    p  = round_sig(TwoPiFMant * 64'(idx), 24);
    x  = p << (39 - lg);
    k  = x / HalfPiQ60;
    r  = x - k * HalfPiQ60;
    t  = OneQ60;
    sp = '0;
    sn = '0;
    cp = OneQ60;
    cn = '0;
    for (int n = 1; n <= 30; n++) begin
      t = mul_q60(t, r) / 64'(n);
      case (n[1:0])
        2'd0:    cp = cp + t;
        2'd1:    sp = sp + t;
        2'd2:    cn = cn + t;
        default: sn = sn + t;
      endcase
    end
    sv  = (sp > sn) ? sp - sn : 64'd0;
    cv  = (cp > cn) ? cp - cn : 64'd0;
    v   = k[0] ? cv : sv;
    v   = round_sig(v, 24);
    mag = v >> 29;
    if (!k[1]) begin
      if (mag > PosMax) mag = PosMax;
      return mag[SampleW-1:0];
    end
    if (mag > NegMax) mag = NegMax;
    return SampleW'(0) - mag[SampleW-1:0];
  endfunction

endpackage

/* rtl/sitd_rom.sv */
module sitd_rom #(
  parameter int unsigned TABLE_SIZE = 256
) (
  input  logic                              clk_i,
  input  logic                              rd_en_i,
  input  logic [$clog2(TABLE_SIZE)-1:0]     rd_addr_i,
  output logic [sitd_pkg::SampleW-1:0]      rd_data_o
);
  import sitd_pkg::*;

  localparam int unsigned TableAw = $clog2(TABLE_SIZE);

  logic [SampleW-1:0] tab [TABLE_SIZE];
  logic [SampleW-1:0] rd_data_q;

  for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_tab
    localparam logic [SampleW-1:0] Entry = sine_entry(gi, TableAw);
    assign tab[gi] = Entry;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= tab[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/stereo_itd_tone_synth.sv */
// Stereo sine tone generator with an inter-aural delay on the lagging ear.
// Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is high
// (0 phase step, 1 left gain, 2 right gain, 3 delay, 4 pan); write only while
// the block is idle. Bits above a register's width are dropped.
// Input: each request on in_valid_i/in_ready_o carries sample_tick_i; a request
// with the tick low is taken and dropped without a result.
// Output: one stereo frame per tick on out_valid_o/out_ready_i.
// Path: a taken request is held in the middle stage for the ROM and ring read,
// then moves into the output register, where out_valid_o rises.
// Throughput: one request per cycle unless the output stalls, set by the
// single-port sine ROM read and the delay ring read/write; a ring entry written
// in the cycle it is read is forwarded.
// Reset: phase, ring position and fill count clear, registers go to zero; ring
// entries not yet written read as zero through the fill count, with no
// clearing pass.
// Stall: the output register holds its frame, one more request moves into the
// middle stage, then in_ready_o drops until out_ready_i returns.
module stereo_itd_tone_synth #(
  parameter int unsigned RING_DEPTH = 64,
  parameter int unsigned TABLE_SIZE = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sitd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [sitd_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              sample_tick_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [sitd_pkg::SampleW-1:0] left_sample_o,
  output logic signed [sitd_pkg::SampleW-1:0] right_sample_o
);
  import sitd_pkg::*;

  localparam int unsigned RingAw  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned TableAw = $clog2(TABLE_SIZE);
  localparam int unsigned ProdW   = SampleW + GainW + 1;

  typedef struct packed {
    logic mute;
    logic fwd;
    logic dly_ok;
    logic dly_self;
    logic use_l;
    logic use_r;
  } s1_ctrl_t;

  logic [StepW-1:0]  phase_step_q;
  logic [GainW-1:0]  gain_left_q;
  logic [GainW-1:0]  gain_right_q;
  logic [DelayW-1:0] itd_delay_q;
  logic [PanW-1:0]   pan_q;

  logic [StepW-1:0]  phase_q, phase_d;
  logic [RingAw-1:0] wp_q, wp_d;
  logic [RingAw:0]   fill_q, fill_d;

  logic              s1_valid_q, s1_valid_d;
  s1_ctrl_t          s1_q, s1_d;
  logic [RingAw-1:0] s1_wp_q;
  logic [SampleW-1:0] fwd_data_q;

  logic              out_valid_q;
  logic [SampleW-1:0] left_q, left_d;
  logic [SampleW-1:0] right_q, right_d;

  logic [SampleW-1:0] ring_mem [RING_DEPTH];
  logic [SampleW-1:0] ring_rd_q;

  logic              in_acc, work, live, mute, s1_adv, ring_we, hit;
  logic [RingAw-1:0] dly, rd_addr;
  logic [SampleW-1:0] raw, dly_mem, dly_val, sl, sr;
  logic signed [ProdW-1:0] prod_l, prod_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      gain_left_q  <= '0;
      gain_right_q <= '0;
      itd_delay_q  <= '0;
      pan_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PHASE_STEP:    phase_step_q <= cfg_data_i[StepW-1:0];
        REG_GAIN_LEFT:     gain_left_q  <= cfg_data_i[GainW-1:0];
        REG_GAIN_RIGHT:    gain_right_q <= cfg_data_i[GainW-1:0];
        REG_ITD_DELAY:     itd_delay_q  <= cfg_data_i[DelayW-1:0];
        REG_PAN_DIRECTION: pan_q        <= cfg_data_i[PanW-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign work       = in_acc && sample_tick_i;
  assign mute       = (gain_left_q == '0) && (gain_right_q == '0);
  assign live       = work && !mute;
  assign ring_we    = s1_adv && !s1_q.mute;

  assign dly     = RingAw'(itd_delay_q);
  assign rd_addr = wp_q - dly;
  assign hit     = s1_valid_q && !s1_q.mute && (rd_addr == s1_wp_q);

  always_comb begin
    phase_d = phase_q;
    wp_d    = wp_q;
    fill_d  = fill_q;
    if (work) begin
      phase_d = phase_q + phase_step_q;
    end
    if (live) begin
      wp_d = wp_q + RingAw'(1);
      if (fill_q != (RingAw + 1)'(RING_DEPTH)) begin
        fill_d = fill_q + (RingAw + 1)'(1);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = sample_tick_i;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    s1_d.mute     = mute;
    s1_d.fwd      = hit;
    s1_d.dly_ok   = fill_q >= {1'b0, dly};
    s1_d.dly_self = (dly == '0);
    s1_d.use_l    = (itd_delay_q != '0) && (pan_q == PanLeft);
    s1_d.use_r    = (itd_delay_q != '0) && pan_q[PanW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      wp_q       <= '0;
      fill_q     <= '0;
      s1_valid_q <= 1'b0;
      s1_q       <= '0;
    end else begin
      phase_q    <= phase_d;
      wp_q       <= wp_d;
      fill_q     <= fill_d;
      s1_valid_q <= s1_valid_d;
      if (work) begin
        s1_q <= s1_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (live) begin
      s1_wp_q <= wp_q;
    end
    if (live && hit) begin
      fwd_data_q <= raw;
    end
  end

  sitd_rom #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_rom (
    .clk_i    (clk_i),
    .rd_en_i  (live),
    .rd_addr_i(phase_q[FracW +: TableAw]),
    .rd_data_o(raw)
  );

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[s1_wp_q] <= raw;
    end
    if (live) begin
      ring_rd_q <= ring_mem[rd_addr];
    end
  end

  assign dly_mem = s1_q.fwd ? fwd_data_q : ring_rd_q;
  assign dly_val = s1_q.dly_self ? raw : (s1_q.dly_ok ? dly_mem : '0);
  assign sl      = s1_q.use_l ? dly_val : raw;
  assign sr      = s1_q.use_r ? dly_val : raw;

  assign prod_l = $signed(sl) * $signed({1'b0, gain_left_q});
  assign prod_r = $signed(sr) * $signed({1'b0, gain_right_q});

  always_comb begin
    left_d  = prod_l[ShiftQ +: SampleW];
    right_d = prod_r[ShiftQ +: SampleW];
    if (s1_q.mute) begin
      left_d  = '0;
      right_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (RingAw + 1)'(RING_DEPTH))
    else $error("fill count past ring depth");

  a_fill_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> fill_q >= $past(fill_q))
    else $error("fill count went down");

  a_wp_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live |=> wp_q == $past(wp_q) + RingAw'(1))
    else $error("ring position did not advance");

  a_mute_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_q.mute) |=> (left_q == '0) && (right_q == '0))
    else $error("muted frame not zero");

  a_fwd_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live && hit) |-> s1_adv)
    else $error("forward taken without write back");

endmodule
